[rtl/slr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants for the stereo linear resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_OUTPUTS_DEF = 8;

  localparam int FRAC_W   = 16;  // phase fraction, gain, multiplier steps
  localparam int PHASE_W  = 20;  // Q4.16 phase, also reciprocal quotient bits
  localparam int RATIO_W  = 20;  // Q4.16 smoothed ratio (0.125 .. 8.0)
  localparam int TARGET_W = 12;
  localparam int GAIN_W   = 16;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_STEPS = FRAC_W;
  localparam int DIV_STEPS = PHASE_W;
  localparam int CYC_W     = $clog2(DIV_STEPS);

  localparam logic [TARGET_W-1:0] RATIO_MIN  = TARGET_W'(32);
  localparam logic [TARGET_W-1:0] RATIO_MAX  = TARGET_W'(2048);
  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(256);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = '1;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = RATIO_W'(1) << FRAC_W;
  localparam logic [PHASE_W-1:0]  PHASE_ONE  = PHASE_W'(1) << FRAC_W;
  // remainder seed: 2^32 >> DIV_STEPS
  localparam logic [RATIO_W-1:0]  RECIP_REM0 = RATIO_W'(1) << (32 - DIV_STEPS);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_RATIO   = 1'b0,
    REG_SMOOTHING_GAIN = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
  } ser_ctl_t;

endpackage

[rtl/slr_ser_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_ser_mul
// Bit-serial signed x unsigned multiplier, LSB first, one multiplier bit per cycle
// while step is high. Gives floor((a*b + 2^(FRAC_W-1)) / 2^FRAC_W) after MUL_STEPS steps.
// ----------------------------------------------------------------------------
module slr_ser_mul
  import slr_pkg::*;
#(
  parameter int AW = 17
) (
  input  logic                clk,
  input  ser_ctl_t            ctl,
  input  logic signed [AW-1:0] a_i,
  input  logic [FRAC_W-1:0]   b_i,
  output logic signed [AW:0]  rnd_o
);

  logic signed [AW-1:0] a_r;
  logic [FRAC_W-1:0]    b_r;
  logic signed [AW-1:0] hi_r;
  logic [FRAC_W-1:0]    lo_r;
  logic signed [AW:0]   sum;

  assign sum = {hi_r[AW-1], hi_r} + (b_r[0] ? {a_r[AW-1], a_r} : '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r  <= a_i;
      b_r  <= b_i;
      hi_r <= '0;
      lo_r <= '0;
    end else if (ctl.step) begin
      hi_r <= sum[AW:1];
      lo_r <= {sum[0], lo_r[FRAC_W-1:1]};
      b_r  <= b_r >> 1;
    end
  end

  assign rnd_o = {hi_r[AW-1], hi_r} + (AW+1)'(lo_r[FRAC_W-1]);

endmodule

[rtl/slr_recip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slr_recip
// Restoring divider, one quotient bit per cycle while step is high:
// (2^32 + s/2) / s, rounded phase step in Q4.16, for s in Q4.16 between 0.125 and 8.0.
// ----------------------------------------------------------------------------
module slr_recip
  import slr_pkg::*;
(
  input  logic               clk,
  input  ser_ctl_t           ctl,
  input  logic [RATIO_W-1:0] s_i,
  output logic [PHASE_W-1:0] q_o
);

  logic [RATIO_W-1:0] s_r;
  logic [RATIO_W-1:0] rem_r;
  logic [RATIO_W-1:0] dvd_r;
  logic [PHASE_W-1:0] q_r;
  logic [RATIO_W:0]   trial;
  logic               ge;

  assign trial = {rem_r, dvd_r[RATIO_W-1]};
  assign ge    = trial >= {1'b0, s_r};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      s_r   <= s_i;
      rem_r <= RECIP_REM0;
      dvd_r <= {1'b0, s_i[RATIO_W-1:1]};
      q_r   <= '0;
    end else if (ctl.step) begin
      rem_r <= ge ? RATIO_W'(trial - {1'b0, s_r}) : trial[RATIO_W-1:0];
      dvd_r <= dvd_r << 1;
      q_r   <= {q_r[PHASE_W-2:0], ge};
    end
  end

  assign q_o = q_r;

endmodule

[rtl/stereo_linear_resampler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top
// Linear-interpolation sample-rate converter for stereo Q1.15 pairs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one stereo pair per beat, tdata = {right, left}, left in low bits.
//   out_* : interpolated pairs, same packing; tlast marks the final output
//           caused by an input pair.
//   cfg_* : write-only registers, index 0 target ratio (Q4.8), 1 smoothing
//           gain (Q0.16); write only while the block is idle.
//   Each output runs through ST_MUL, the bit-serial multiply (both
//   interpolations and the ratio smoothing run side by side), ST_SMOOTH to
//   fold results, ST_DIV, the one-bit-per-cycle reciprocal divider, and
//   ST_EMIT to load the output register. After its last output a pair
//   returns the block to idle before the next pair is taken; a pair that
//   causes no output is taken in idle alone. in_tready is high only between pairs.
//   The output register decouples the sides: a new pair is accepted while the
//   last result still waits. A stalled receiver holds the block in its emit
//   cycle until the output register frees up.
//   Reset (rst_n low, synchronous) clears phase, priming and ratio to 1.0;
//   the first pair after reset only primes the history.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_top
  import slr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // left_in, right_in
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // left_out, right_out
  output logic                                   out_tlast,
  input  logic                                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]                  cfg_addr,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int DATA_W = ((2*SB+7)/8)*8;
  localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_SMOOTH = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [TARGET_W-1:0]   target_r;
  logic [GAIN_W-1:0]     gain_r;
  logic                  primed_r, primed_nxt;
  logic [PHASE_W-1:0]    phase_r, phase_nxt;
  logic [RATIO_W-1:0]    ratio_r, ratio_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CYC_W-1:0]      cyc_r, cyc_nxt;
  logic signed [SB-1:0]  prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic signed [SB-1:0]  cur_l_r, cur_l_nxt, cur_r_r, cur_r_nxt;
  logic signed [SB-1:0]  ip_l_r, ip_l_nxt, ip_r_r, ip_r_nxt;
  logic signed [SB-1:0]  ol_r, ol_nxt, or_r, or_nxt;
  logic                  olast_r, olast_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic                  in_acc;
  logic signed [SB-1:0]  in_l, in_r, src_l, src_r;
  logic signed [SB:0]    d_l, d_r;
  logic signed [SB+1:0]  res_l, res_r;
  logic [TARGET_W-1:0]   tr_cl;
  logic [RATIO_W-1:0]    tgt;
  logic signed [RATIO_W:0]   rdiff;
  logic signed [RATIO_W+1:0] rdelta;
  logic [RATIO_W-1:0]    ratio_new;
  logic [PHASE_W-1:0]    step_q, ph_sum, ph_fin;
  logic [FRAC_W-1:0]     mul_t;
  logic [CNT_W-1:0]      n_inc;
  logic                  emit_last;
  ser_ctl_t              mul_ctl, div_ctl;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TARGET_RATIO:   target_r <= cfg_wdata[TARGET_W-1:0];
        REG_SMOOTHING_GAIN: gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign in_l   = $signed(in_tdata[SB-1:0]);
  assign in_r   = $signed(in_tdata[2*SB-1:SB]);
  assign in_acc = in_tvalid && in_tready;

  assign src_l = (state_r == ST_IDLE) ? in_l : cur_l_r;
  assign src_r = (state_r == ST_IDLE) ? in_r : cur_r_r;
  assign d_l   = {src_l[SB-1], src_l} - {prev_l_r[SB-1], prev_l_r};
  assign d_r   = {src_r[SB-1], src_r} - {prev_r_r[SB-1], prev_r_r};

  // next output in a run interpolates at the phase being written this cycle
  assign mul_t = (state_r == ST_EMIT) ? ph_fin[FRAC_W-1:0] : phase_r[FRAC_W-1:0];

  assign tr_cl = (target_r < RATIO_MIN) ? RATIO_MIN :
                 (target_r > RATIO_MAX) ? RATIO_MAX : target_r;
  assign tgt   = {tr_cl, 8'd0};
  assign rdiff = $signed({1'b0, tgt} - {1'b0, ratio_r});
  assign ratio_new = ratio_r + rdelta[RATIO_W-1:0];

  slr_ser_mul #(.AW(SB+1)) u_mul_l (
    .clk(clk), .ctl(mul_ctl), .a_i(d_l), .b_i(mul_t), .rnd_o(res_l)
  );

  slr_ser_mul #(.AW(SB+1)) u_mul_r (
    .clk(clk), .ctl(mul_ctl), .a_i(d_r), .b_i(mul_t), .rnd_o(res_r)
  );

  slr_ser_mul #(.AW(RATIO_W+1)) u_mul_s (
    .clk(clk), .ctl(mul_ctl), .a_i(rdiff), .b_i(gain_r), .rnd_o(rdelta)
  );

  slr_recip u_recip (
    .clk(clk), .ctl(div_ctl), .s_i(ratio_new), .q_o(step_q)
  );

  assign ph_sum    = phase_r + step_q;
  assign n_inc     = n_r + CNT_W'(1);
  assign ph_fin    = (ph_sum < PHASE_ONE && n_inc >= CNT_W'(MAX_OUTPUTS)) ?
                     PHASE_ONE : ph_sum;
  assign emit_last = ph_fin >= PHASE_ONE;

  // ---------------- control ----------------
  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    phase_nxt  = phase_r;
    ratio_nxt  = ratio_r;
    n_nxt      = n_r;
    cyc_nxt    = cyc_r;
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    cur_l_nxt  = cur_l_r;
    cur_r_nxt  = cur_r_r;
    ip_l_nxt   = ip_l_r;
    ip_r_nxt   = ip_r_r;
    ol_nxt     = ol_r;
    or_nxt     = or_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_tready;
    mul_ctl    = '0;
    div_ctl    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!primed_r) begin
            primed_nxt = 1'b1;
            prev_l_nxt = in_l;
            prev_r_nxt = in_r;
          end else if (phase_r >= PHASE_ONE) begin
            phase_nxt  = phase_r - PHASE_ONE;
            prev_l_nxt = in_l;
            prev_r_nxt = in_r;
          end else begin
            cur_l_nxt    = in_l;
            cur_r_nxt    = in_r;
            n_nxt        = '0;
            cyc_nxt      = '0;
            mul_ctl.load = 1'b1;
            state_nxt    = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        mul_ctl.step = 1'b1;
        cyc_nxt      = cyc_r + CYC_W'(1);
        if (cyc_r == CYC_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        ip_l_nxt     = SB'(prev_l_r + res_l[SB-1:0]);
        ip_r_nxt     = SB'(prev_r_r + res_r[SB-1:0]);
        ratio_nxt    = ratio_new;
        div_ctl.load = 1'b1;
        cyc_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cyc_nxt      = cyc_r + CYC_W'(1);
        if (cyc_r == CYC_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ol_nxt     = ip_l_r;
          or_nxt     = ip_r_r;
          olast_nxt  = emit_last;
          n_nxt      = n_inc;
          if (emit_last) begin
            phase_nxt  = ph_fin - PHASE_ONE;
            prev_l_nxt = cur_l_r;
            prev_r_nxt = cur_r_r;
            state_nxt  = ST_IDLE;
          end else begin
            phase_nxt    = ph_fin;
            cyc_nxt      = '0;
            mul_ctl.load = 1'b1;
            state_nxt    = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      primed_r <= 1'b0;
      phase_r  <= '0;
      ratio_r  <= RATIO_RST;
      n_r      <= '0;
      cyc_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      primed_r <= primed_nxt;
      phase_r  <= phase_nxt;
      ratio_r  <= ratio_nxt;
      n_r      <= n_nxt;
      cyc_r    <= cyc_nxt;
      ovalid_r <= ovalid_nxt;
      prev_l_r <= prev_l_nxt;
      prev_r_r <= prev_r_nxt;
      cur_l_r  <= cur_l_nxt;
      cur_r_r  <= cur_r_nxt;
      ip_l_r   <= ip_l_nxt;
      ip_r_r   <= ip_r_nxt;
      ol_r     <= ol_nxt;
      or_r     <= or_nxt;
      olast_r  <= olast_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = DATA_W'({or_r, ol_r});

  // ---------------- checks ----------------
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_r >= {RATIO_MIN, 8'd0} && ratio_r <= {RATIO_MAX, 8'd0})
    else $error("smoothed ratio out of range");

  a_phase_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> phase_r < PHASE_ONE)
    else $error("interpolating with phase at or above one");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r == ST_EMIT))
    else $error("output raised outside emit");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_OUTPUTS))
    else $error("output count beyond cap");

  a_prime_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> state_r == ST_IDLE)
    else $error("busy before priming");

endmodule
